>>> rtl/lfgr_pkg.sv
// Package for the linear fade gain ramp: widths, register map, state codes
// and the structs passed between the CSR block, the serial multiplier and the divider.
// No dependencies.
package lfgr_pkg;

   localparam int COUNT_BITS = 24;
   localparam int PCT_W      = 10;
   localparam int SAMPLE_W   = 16;
   localparam int DIFF_W     = PCT_W + 1;
   localparam int SAT_W      = 22;
   localparam int DIV_W      = (COUNT_BITS + PCT_W > SAT_W) ? COUNT_BITS + PCT_W : SAT_W;
   localparam int GAIN_W     = DIV_W + 2;
   localparam int MCAND_W    = (COUNT_BITS > SAT_W) ? COUNT_BITS : SAT_W;
   localparam int MUL_STEPS  = SAMPLE_W;
   localparam int ACC_W      = MCAND_W + SAMPLE_W;
   localparam int MCNT_W     = $clog2(MUL_STEPS);
   localparam int DCNT_W     = $clog2(DIV_W);
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   typedef logic [COUNT_BITS-1:0]      count_type;
   typedef logic [PCT_W-1:0]           pct_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam logic [SAT_W-1:0]    GAIN_SAT    = '1;
   localparam count_type           PCT_DIVISOR = count_type'(100);
   localparam logic [SAMPLE_W-1:0] CLAMP8_POS  = 16'h007F;
   localparam logic [SAMPLE_W-1:0] CLAMP8_NEG  = 16'hFF81;
   localparam logic [SAMPLE_W-1:0] MAX16       = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] MIN16       = 16'h8000;

   localparam pct_type   RST_START  = pct_type'(70);
   localparam pct_type   RST_END    = pct_type'(100);
   localparam count_type RST_COUNT  = count_type'(1);
   localparam logic      RST_WIDE   = 1'b1;
   localparam logic      RST_STEREO = 1'b0;

   typedef enum logic [2:0] {
      REG_START  = 3'd0,
      REG_END    = 3'd1,
      REG_COUNT  = 3'd2,
      REG_WIDE   = 3'd3,
      REG_STEREO = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_OUT
   } state_type;

   typedef struct packed {
      pct_type   start_percent;
      pct_type   end_percent;
      count_type sample_count;
      logic      wide_samples;
      logic      stereo_mode;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [SAMPLE_W-1:0] mplier;
   } mul_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] product;
   } mul_sts_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      count_type        divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

endpackage

>>> rtl/lfgr_if.sv
// Valid/ready channel interfaces for the sample request and response streams.
// Depends on lfgr_pkg.
interface lfgr_req_if;
   import lfgr_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface lfgr_rsp_if;
   import lfgr_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       last;
   modport source (output valid, output sample_out, output last, input ready);
   modport sink (input valid, input sample_out, input last, output ready);
endinterface

>>> rtl/lfgr_csr.sv
// APB-style configuration registers of the fade ramp.
// Depends on lfgr_pkg.
module lfgr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lfgr_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lfgr_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lfgr_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output lfgr_pkg::cfg_type            cfg
);
   import lfgr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type index;
   logic    wr_en;

   assign index      = reg_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_START:  cfg_in.start_percent = csr_pwdata[PCT_W-1:0];
            REG_END:    cfg_in.end_percent   = csr_pwdata[PCT_W-1:0];
            REG_COUNT:  cfg_in.sample_count  = csr_pwdata[COUNT_BITS-1:0];
            REG_WIDE:   cfg_in.wide_samples  = csr_pwdata[0];
            REG_STEREO: cfg_in.stereo_mode   = csr_pwdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_START:  csr_prdata = DATA_W'(cfg_ff.start_percent);
         REG_END:    csr_prdata = DATA_W'(cfg_ff.end_percent);
         REG_COUNT:  csr_prdata = DATA_W'(cfg_ff.sample_count);
         REG_WIDE:   csr_prdata = DATA_W'(cfg_ff.wide_samples);
         REG_STEREO: csr_prdata = DATA_W'(cfg_ff.stereo_mode);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_percent <= RST_START;
         cfg_ff.end_percent   <= RST_END;
         cfg_ff.sample_count  <= RST_COUNT;
         cfg_ff.wide_samples  <= RST_WIDE;
         cfg_ff.stereo_mode   <= RST_STEREO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/lfgr_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Shared by the ramp product and the sample scaling. Depends on lfgr_pkg.
module lfgr_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  lfgr_pkg::mul_ctl_type ctl,
   output lfgr_pkg::mul_sts_type sts
);
   import lfgr_pkg::*;

   logic [ACC_W-1:0]    mcand_ff, mcand_in;
   logic [SAMPLE_W-1:0] mplier_ff, mplier_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [MCNT_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         mcand_in  = ACC_W'(ctl.mcand);
         mplier_in = ctl.mplier;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[SAMPLE_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == MCNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign sts.busy    = busy_ff;
   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

endmodule

>>> rtl/lfgr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Shared by the ramp division and the divide by 100. Depends on lfgr_pkg.
module lfgr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  lfgr_pkg::div_ctl_type ctl,
   output lfgr_pkg::div_sts_type sts
);
   import lfgr_pkg::*;

   logic [DIV_W-1:0]    quo_ff, quo_in;
   count_type           rem_ff, rem_in;
   count_type           divisor_ff, divisor_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [COUNT_BITS:0] trial;
   logic [COUNT_BITS:0] trial_sub;
   logic                fits;

   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign fits      = trial >= {1'b0, divisor_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (ctl.start) begin
         quo_in     = ctl.dividend;
         rem_in     = '0;
         divisor_in = ctl.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

>>> rtl/linear_fade_gain_ramp_top.sv
// Linear fade gain ramp: each scaled sample runs the shared bit-serial multiplier
// and restoring divider twice (ramp product, ramp division, sample scaling, divide
// by 100). Skipped odd stereo samples go straight to the output state. Samples are
// taken only in idle. Output register lets a new transaction start while a result
// waits. Synchronous reset loads register defaults and clears the position.
module linear_fade_gain_ramp_top (
   input  logic                         clock,
   input  logic                         reset,
   lfgr_req_if.sink                     req,
   lfgr_rsp_if.source                   rsp,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lfgr_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lfgr_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lfgr_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import lfgr_pkg::*;

   cfg_type     cfg;
   mul_ctl_type mul_ctl;
   mul_sts_type mul_sts;
   div_ctl_type div_ctl;
   div_sts_type div_sts;

   state_type           state_ff, state_in;
   count_type           position_ff, position_in;
   sample_type          s_ff, s_in;
   logic                last_ff, last_in;
   logic                gain_neg_ff, gain_neg_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;

   count_type           len;
   logic                is_last;
   logic [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]   diff_abs;
   logic [GAIN_W-1:0]   q_ext;
   logic [GAIN_W-1:0]   q_sgn;
   logic [GAIN_W-1:0]   gain;
   logic [GAIN_W-1:0]   gain_abs;
   logic [SAT_W-1:0]    gain_sat;
   logic [SAT_W-1:0]    prod_sat;
   logic [SAMPLE_W-1:0] s_bits;
   logic [SAMPLE_W-1:0] s_abs;
   logic [SAMPLE_W-1:0] m_lo;
   logic                m_big;
   logic                res_neg;
   logic                over;
   logic [SAMPLE_W-1:0] res_clamp;

   lfgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfgr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .sts   (mul_sts)
   );

   lfgr_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // ramp position and gain
   assign len      = (cfg.sample_count == '0) ? count_type'(1) : cfg.sample_count;
   assign is_last  = ({1'b0, position_ff} + 1'b1) >= {1'b0, len};
   assign diff     = {1'b0, cfg.end_percent} - {1'b0, cfg.start_percent};
   assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
   assign q_ext    = GAIN_W'(div_sts.quotient);
   assign q_sgn    = diff[DIFF_W-1] ? (~q_ext + 1'b1) : q_ext;
   assign gain     = GAIN_W'(cfg.start_percent) + q_sgn;
   assign gain_abs = gain[GAIN_W-1] ? (~gain + 1'b1) : gain;
   // beyond these magnitudes the result saturates anyway
   assign gain_sat = (|gain_abs[GAIN_W-1:SAT_W]) ? GAIN_SAT : gain_abs[SAT_W-1:0];
   assign prod_sat = (|mul_sts.product[ACC_W-1:SAT_W]) ? GAIN_SAT
                                                       : mul_sts.product[SAT_W-1:0];
   assign s_bits   = s_ff;
   assign s_abs    = s_bits[SAMPLE_W-1] ? (~s_bits + 1'b1) : s_bits;

   // clamp
   assign m_lo    = div_sts.quotient[SAMPLE_W-1:0];
   assign m_big   = |div_sts.quotient[DIV_W-1:SAMPLE_W];
   assign res_neg = s_bits[SAMPLE_W-1] ^ gain_neg_ff;

   always_comb begin
      if (cfg.wide_samples) begin
         over = m_big || m_lo[SAMPLE_W-1];
         if (res_neg) begin
            res_clamp = over ? MIN16 : (~m_lo + 1'b1);
         end else begin
            res_clamp = over ? MAX16 : m_lo;
         end
      end else begin
         over = m_big || (m_lo >= CLAMP8_POS);
         if (res_neg) begin
            res_clamp = over ? CLAMP8_NEG : (~m_lo + 1'b1);
         end else begin
            res_clamp = over ? CLAMP8_POS : m_lo;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      position_in   = position_ff;
      s_in          = s_ff;
      last_in       = last_ff;
      gain_neg_in   = gain_neg_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      mul_ctl       = '0;
      div_ctl       = '0;
      req.ready     = (state_ff == ST_IDLE);
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               s_in        = req.sample_in;
               last_in     = is_last;
               position_in = is_last ? '0 : position_ff + 1'b1;
               if (cfg.stereo_mode && position_ff[0]) begin
                  res_in   = req.sample_in;
                  state_in = ST_OUT;
               end else begin
                  mul_ctl.start  = 1'b1;
                  mul_ctl.mcand  = MCAND_W'(position_ff);
                  mul_ctl.mplier = SAMPLE_W'(diff_abs);
                  state_in       = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            if (mul_sts.done) begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = mul_sts.product[DIV_W-1:0];
               div_ctl.divisor  = len;
               state_in         = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_sts.done) begin
               gain_neg_in    = gain[GAIN_W-1];
               mul_ctl.start  = 1'b1;
               mul_ctl.mcand  = MCAND_W'(gain_sat);
               mul_ctl.mplier = s_abs;
               state_in       = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_sts.done) begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = DIV_W'(prod_sat);
               div_ctl.divisor  = PCT_DIVISOR;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_sts.done) begin
               res_in   = res_clamp;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      last_ff       <= last_in;
      gain_neg_ff   <= gain_neg_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.last       = rsp_last_ff;

`ifndef SYNTH
   a_units_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.done && div_sts.done))
      else $error("multiplier and divider finished together");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   a_idle_units_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!mul_sts.busy && !div_sts.busy))
      else $error("arithmetic unit busy while idle");
`endif

endmodule
